// ----- rtl/hgcd_pkg.sv -----
// Shared types, constants and helper functions for the haversine distance pipeline.
// No dependencies; every other file in rtl/ imports this package.
package hgcd_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 28;
    localparam int CORDIC_ITER_DEF     = 24;

    localparam int LAT_W    = 30;
    localparam int LON_W    = 31;
    localparam int RADIUS_W = 23;
    localparam int DIST_W   = 33;

    localparam int CW       = 34;   // CORDIC / Q30 datapath width
    localparam int RW       = 36;   // reduced angle width
    localparam int A_W      = 31;   // a in [0, 1.0] Q30
    localparam int ROOT_W   = 31;
    localparam int SQ_STEPS = 31;   // one result bit per stage
    localparam int SQ_N_W   = 2 * SQ_STEPS;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

    localparam logic signed [RW-1:0] PI_Q      = 36'sd3373259426;
    localparam logic signed [RW-1:0] TWO_PI_Q  = 36'sd6746518852;
    localparam logic signed [RW-1:0] HALF_PI_Q = 36'sd1686629713;
    localparam logic signed [CW-1:0] CORDIC_K  = 34'sd652032874;
    localparam logic signed [CW:0]   ONE_Q     = 35'sd1073741824;

    function automatic logic signed [CW-1:0] atan_q(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0:       v = 34'sh03243F6A8;
            1:       v = 34'sh01DAC6705;
            2:       v = 34'sh00FADBAFC;
            3:       v = 34'sh007F56EA6;
            4:       v = 34'sh003FEAB76;
            5:       v = 34'sh001FFD55B;
            6:       v = 34'sh000FFFAAA;
            7:       v = 34'sh0007FFF55;
            8:       v = 34'sh0003FFFEA;
            9:       v = 34'sh0001FFFFD;
            10:      v = 34'sh0000FFFFF;
            11:      v = 34'sh00007FFFF;
            12:      v = 34'sh00003FFFF;
            13:      v = 34'sh00001FFFF;
            14:      v = 34'sh00000FFFF;
            15:      v = 34'sh000007FFF;
            16:      v = 34'sh000003FFF;
            17:      v = 34'sh000001FFF;
            18:      v = 34'sh000000FFF;
            19:      v = 34'sh0000007FF;
            20:      v = 34'sh0000003FF;
            21:      v = 34'sh0000001FF;
            22:      v = 34'sh0000000FF;
            23:      v = 34'sh00000007F;
            24:      v = 34'sh00000003F;
            25:      v = 34'sh00000001F;
            26:      v = 34'sh00000000F;
            27:      v = 34'sh000000008;
            28:      v = 34'sh000000004;
            29:      v = 34'sh000000002;
            30:      v = 34'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q30 product, rounded half up
    function automatic logic signed [CW-1:0] mulq(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        p = a * b;
        p = p + (2*CW)'(64'sd536870912);
        return CW'(p >>> 30);
    endfunction

endpackage

// ----- rtl/hgcd_cordic_iter.sv -----
// One registered CORDIC micro-rotation, rotation or vectoring mode.
// Depends on hgcd_pkg for the datapath width and the arctangent table.
module hgcd_cordic_iter
    import hgcd_pkg::*;
#(
    parameter int IDX = 0,
    parameter bit VEC = 1'b0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [CW-1:0] i_z,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [CW-1:0] o_z
);

    localparam logic signed [CW-1:0] ATAN = atan_q(IDX);

    logic signed [CW-1:0] r_x, r_y, r_z;
    logic signed [CW-1:0] w_dx, w_dy;
    logic                 w_pos, w_sub;

    assign w_dx  = i_y >>> IDX;
    assign w_dy  = i_x >>> IDX;
    assign w_pos = VEC ? ~i_y[CW-1] : ~i_z[CW-1];
    assign w_sub = VEC ? ~w_pos : w_pos;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_sub) begin
                r_x <= i_x - w_dx;
                r_y <= i_y + w_dy;
                r_z <= i_z - ATAN;
            end else begin
                r_x <= i_x + w_dx;
                r_y <= i_y - w_dy;
                r_z <= i_z + ATAN;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ----- rtl/hgcd_sincos.sv -----
// Pipelined sine/cosine: modulo-2pi reduction by reciprocal multiply, quadrant fold,
// then one CORDIC iteration per stage. Depends on hgcd_pkg and hgcd_cordic_iter.
module hgcd_sincos
    import hgcd_pkg::*;
#(
    parameter int TH_W  = 35,
    parameter int ITERS = CORDIC_ITER_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [TH_W-1:0] i_th,
    output logic signed [CW-1:0]   o_sin,
    output logic signed [CW-1:0]   o_cos
);

    localparam int ITER_N = (ITERS < 32) ? ITERS : 32;
    localparam int SH     = TH_W + 2;
    localparam int RCW    = SH - 32;
    localparam int QW     = TH_W - 31;
    localparam int PW     = TH_W + RCW + 1;
    localparam int MW     = QW + RW;
    localparam int DW     = TH_W + 5;
    localparam logic [63:0]    RECIP64 = (64'd1 << SH) / 64'(TWO_PI_Q);
    localparam logic [RCW-1:0] RECIP   = RECIP64[RCW-1:0];

    logic signed [TH_W-1:0] r1_th, r2_th;
    logic signed [PW-1:0]   r1_p;
    logic signed [MW-1:0]   r2_q2;
    logic signed [RW-1:0]   r3_r;
    logic signed [CW-1:0]   r4_z;
    logic                   r4_neg;
    logic signed [QW-1:0]   w_q;
    logic signed [DW-1:0]   w_d;
    logic signed [RW-1:0]   w_r, w_t;
    logic signed [RW-1:0]   n3_r, n4_z;
    logic                   n4_neg;
    logic [ITER_N-1:0]      r_neg;
    logic signed [CW-1:0]   r_sin, r_cos;
    logic signed [CW-1:0]   w_x [0:ITER_N];
    logic signed [CW-1:0]   w_y [0:ITER_N];
    logic signed [CW-1:0]   w_z [0:ITER_N];

    assign w_q = QW'(r1_p >>> SH);
    assign w_d = DW'(r2_th) - DW'(r2_q2);
    assign w_r = w_d[RW-1:0];

    always_comb begin
        if (w_r[RW-1]) begin
            n3_r = w_r + TWO_PI_Q;
        end else if (w_r >= TWO_PI_Q) begin
            n3_r = w_r - TWO_PI_Q;
        end else begin
            n3_r = w_r;
        end
    end

    assign w_t = (r3_r >= PI_Q) ? (r3_r - TWO_PI_Q) : r3_r;

    always_comb begin
        n4_neg = 1'b1;
        if (w_t > HALF_PI_Q) begin
            n4_z = PI_Q - w_t;
        end else if (w_t < -HALF_PI_Q) begin
            n4_z = -PI_Q - w_t;
        end else begin
            n4_z   = w_t;
            n4_neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_th  <= i_th;
            r1_p   <= i_th * $signed({1'b0, RECIP});
            r2_th  <= r1_th;
            r2_q2  <= w_q * TWO_PI_Q;
            r3_r   <= n3_r;
            r4_z   <= n4_z[CW-1:0];
            r4_neg <= n4_neg;
        end
    end

    assign w_x[0] = CORDIC_K;
    assign w_y[0] = '0;
    assign w_z[0] = r4_z;

    for (genvar i = 0; i < ITER_N; i++) begin : g_iter
        hgcd_cordic_iter #(
            .IDX (i),
            .VEC (1'b0)
        ) u_iter (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x   (w_x[i]),
            .i_y   (w_y[i]),
            .i_z   (w_z[i]),
            .o_x   (w_x[i+1]),
            .o_y   (w_y[i+1]),
            .o_z   (w_z[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= ITER_N'({r_neg, r4_neg});
            r_sin <= w_y[ITER_N];
            r_cos <= r_neg[ITER_N-1] ? -w_x[ITER_N] : w_x[ITER_N];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ----- rtl/hgcd_isqrt.sv -----
// Pipelined floor square root of (value * 2^30), one result bit per stage.
// Depends on hgcd_pkg for widths and the stage count.
module hgcd_isqrt
    import hgcd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [A_W-1:0]    i_val,
    output logic [ROOT_W-1:0] o_root
);

    logic [SQ_N_W-1:0] w_n    [0:SQ_STEPS];
    logic [32:0]       w_rem  [0:SQ_STEPS];
    logic [ROOT_W-1:0] w_root [0:SQ_STEPS];

    assign w_n[0]    = {1'b0, i_val, 30'd0};
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        logic [SQ_N_W-1:0] r_n;
        logic [32:0]       r_rem;
        logic [ROOT_W-1:0] r_root;
        logic [34:0]       w_sh, w_trial, w_diff;
        logic              w_ge;

        assign w_sh    = {w_rem[k], w_n[k][SQ_N_W-1-2*k -: 2]};
        assign w_trial = {2'b00, w_root[k], 2'b01};
        assign w_diff  = w_sh - w_trial;
        assign w_ge    = (w_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n    <= w_n[k];
                r_rem  <= w_ge ? w_diff[32:0] : w_sh[32:0];
                r_root <= {w_root[k][ROOT_W-2:0], w_ge};
            end
        end

        assign w_n[k+1]    = r_n;
        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
    end

    assign o_root = w_root[SQ_STEPS];

endmodule

// ----- rtl/hgcd_atan2.sv -----
// Pipelined vectoring-mode CORDIC giving atan2(y, x) for non-negative x and y.
// Depends on hgcd_pkg and hgcd_cordic_iter.
module hgcd_atan2
    import hgcd_pkg::*;
#(
    parameter int ITERS = CORDIC_ITER_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [ROOT_W-1:0]    i_y,
    input  logic [ROOT_W-1:0]    i_x,
    output logic signed [CW-1:0] o_ang
);

    localparam int ITER_N = (ITERS < 32) ? ITERS : 32;

    logic signed [CW-1:0] w_x [0:ITER_N];
    logic signed [CW-1:0] w_y [0:ITER_N];
    logic signed [CW-1:0] w_z [0:ITER_N];

    assign w_x[0] = $signed(CW'(i_x));
    assign w_y[0] = $signed(CW'(i_y));
    assign w_z[0] = '0;

    for (genvar i = 0; i < ITER_N; i++) begin : g_iter
        hgcd_cordic_iter #(
            .IDX (i),
            .VEC (1'b1)
        ) u_iter (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x   (w_x[i]),
            .i_y   (w_y[i]),
            .i_z   (w_z[i]),
            .o_x   (w_x[i+1]),
            .o_y   (w_y[i+1]),
            .o_z   (w_z[i+1])
        );
    end

    assign o_ang = w_z[ITER_N];

endmodule

// ----- rtl/haversine_great_circle_distance.sv -----
// Haversine great-circle distance, fully pipelined.
// Input: i_valid/o_ready transaction, two lat/lon pairs, radians, signed Q2.28/Q3.28.
// Output: o_valid/i_ready transaction carrying o_distance, meters, unsigned Q25.8.
// Config: i_cfg_valid/o_cfg_ready write of the sphere radius in meters; always ready.
//   Write it only while no transaction is in flight.
// Throughput: one transaction per cycle except while the pipeline is frozen.
// Path from input acceptance to o_valid: the input registers, the sine/cosine
//   CORDIC chains, the product registers, the 31-stage square root, the atan2
//   CORDIC chain, the distance register and the output queue.
// Reset (i_rst_n low, synchronous) empties the pipeline and output queue and
//   loads the radius with 6371000.
// Receiver stall: results collect in a two-entry output queue; the pipeline
//   keeps moving and accepting input until the queue is full and the last
//   stage holds a result, then it freezes without losing or repeating anything.
// Depends on hgcd_pkg, hgcd_sincos, hgcd_isqrt, hgcd_atan2.
module haversine_great_circle_distance
    import hgcd_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS   = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [RADIUS_W-1:0]        i_cfg_earth_radius_m,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [LAT_W-1:0]    i_lat_a,
    input  logic signed [LON_W-1:0]    i_lon_a,
    input  logic signed [LAT_W-1:0]    i_lat_b,
    input  logic signed [LON_W-1:0]    i_lon_b,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [DIST_W-1:0]          o_distance
);

    localparam int ITER_N = (CORDIC_ITERATIONS < 32) ? CORDIC_ITERATIONS : 32;
    localparam int TH_W   = 63 - ANGLE_FRAC_BITS;
    localparam int S_FULL = 30 - ANGLE_FRAC_BITS;
    localparam int S_HALF = 29 - ANGLE_FRAC_BITS;
    localparam int SL     = (S_HALF >= 0) ? S_HALF : 0;
    localparam int SR     = (S_HALF >= 0) ? 0 : -S_HALF;
    localparam int LAT    = 41 + 2 * ITER_N;

    logic                   en, pop, push, last_v;
    logic [RADIUS_W-1:0]    r_radius;
    logic [LAT-1:0]         r_vld;
    logic signed [LON_W:0]  w_dlat;
    logic signed [LON_W+1:0] w_dlon;
    logic signed [TH_W-1:0] r_th_dlat, r_th_dlon, r_th_la, r_th_lb;
    logic signed [CW-1:0]   s_dlat, s_dlon, c_la, c_lb;
    logic signed [CW-1:0]   r_slat, r_slon, r_c12, r_slat2, r_t;
    logic signed [CW:0]     w_sum;
    logic [A_W-1:0]         n_a, r_a, r_am;
    logic [ROOT_W-1:0]      root_a, root_am;
    logic signed [CW-1:0]   w_h;
    logic [30:0]            w_hc;
    logic [53:0]            w_prod;
    logic [DIST_W-1:0]      r_dist;
    logic [DIST_W-1:0]      r_mem [0:1];
    logic                   r_wp, r_rp;
    logic [1:0]             r_cnt;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_valid) begin
            r_radius <= i_cfg_earth_radius_m;
        end
    end

    // flow control
    assign last_v  = r_vld[LAT-1];
    assign pop     = o_valid & i_ready;
    assign en      = ~((r_cnt == 2'd2) & last_v & ~pop);
    assign push    = en & last_v;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= LAT'({r_vld, i_valid});
        end
    end

    // angle conversion to Q30
    assign w_dlat = (LON_W+1)'(i_lat_b) - (LON_W+1)'(i_lat_a);
    assign w_dlon = (LON_W+2)'(i_lon_b) - (LON_W+2)'(i_lon_a);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_th_dlat <= (TH_W'(w_dlat) <<< SL) >>> SR;
            r_th_dlon <= (TH_W'(w_dlon) <<< SL) >>> SR;
            r_th_la   <= TH_W'(i_lat_a) <<< S_FULL;
            r_th_lb   <= TH_W'(i_lat_b) <<< S_FULL;
        end
    end

    hgcd_sincos #(.TH_W(TH_W), .ITERS(ITER_N)) u_sc_dlat (
        .i_clk (i_clk), .i_en (en), .i_th (r_th_dlat), .o_sin (s_dlat), .o_cos ()
    );
    hgcd_sincos #(.TH_W(TH_W), .ITERS(ITER_N)) u_sc_dlon (
        .i_clk (i_clk), .i_en (en), .i_th (r_th_dlon), .o_sin (s_dlon), .o_cos ()
    );
    hgcd_sincos #(.TH_W(TH_W), .ITERS(ITER_N)) u_sc_la (
        .i_clk (i_clk), .i_en (en), .i_th (r_th_la), .o_sin (), .o_cos (c_la)
    );
    hgcd_sincos #(.TH_W(TH_W), .ITERS(ITER_N)) u_sc_lb (
        .i_clk (i_clk), .i_en (en), .i_th (r_th_lb), .o_sin (), .o_cos (c_lb)
    );

    // a = sin^2(dlat/2) + cos(lat_a)*cos(lat_b)*sin^2(dlon/2), clamped to [0, 1]
    assign w_sum = (CW+1)'(r_slat2) + (CW+1)'(r_t);

    always_comb begin
        if (w_sum[CW]) begin
            n_a = '0;
        end else if (w_sum > ONE_Q) begin
            n_a = ONE_Q[A_W-1:0];
        end else begin
            n_a = w_sum[A_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_slat  <= mulq(s_dlat, s_dlat);
            r_slon  <= mulq(s_dlon, s_dlon);
            r_c12   <= mulq(c_la, c_lb);
            r_slat2 <= r_slat;
            r_t     <= mulq(r_c12, r_slon);
            r_a     <= n_a;
            r_am    <= ONE_Q[A_W-1:0] - n_a;
        end
    end

    hgcd_isqrt u_sqrt_a (
        .i_clk (i_clk), .i_en (en), .i_val (r_a), .o_root (root_a)
    );
    hgcd_isqrt u_sqrt_am (
        .i_clk (i_clk), .i_en (en), .i_val (r_am), .o_root (root_am)
    );

    hgcd_atan2 #(.ITERS(ITER_N)) u_atan2 (
        .i_clk (i_clk), .i_en (en), .i_y (root_a), .i_x (root_am), .o_ang (w_h)
    );

    // distance = radius * half angle, Q30 -> Q8 with the factor of two folded in
    assign w_hc   = w_h[CW-1] ? '0 : w_h[30:0];
    assign w_prod = 54'(r_radius) * 54'(w_hc) + 54'(1 << 20);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist <= w_prod[53:21];
        end
    end

    // two-entry output queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= r_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    assign o_valid    = (r_cnt != 2'd0);
    assign o_distance = r_mem[r_rp];

endmodule
